// ===== design/assert_macros.svh =====
// assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lsvm check failed");

// next-cycle implication, checked on clk, off during rst
`define ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lsvm check failed");

`endif

// ===== design/lsvm_pkg.sv =====
`default_nettype none
package lsvm_pkg;

  // default geometry
  localparam int DEF_NUM_VOICES  = 128;
  localparam int DEF_VOICE_DEPTH = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed field widths
  localparam int GAIN_W    = 16;
  localparam int FLAGS_W   = 2;
  localparam int MIX_W     = 24;
  localparam int Q_SHIFT   = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // voice must be playing and ready
  localparam logic [FLAGS_W-1:0] FLAG_ACTIVE = 2'b11;

  // no pulse voice
  localparam logic [7:0] PULSE_NONE = 8'd255;

  // mix saturation limits
  localparam int MIX_MAX = 8388607;
  localparam int MIX_MIN = -8388608;
  localparam logic signed [MIX_W-1:0] MIX_SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [MIX_W-1:0] MIX_SAT_MIN = 24'sh800000;

  // operation codes
  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_WR_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_WR_CTRL   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_VOICE = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         voice_index;
    logic [11:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [12:0]        loop_length;
    logic [15:0]        loop_gain;
    logic               loop_playing;
    logic               loop_usable;
    logic               restart_position;
    logic               last_in_block;
  } in_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_sample;
    logic                    any_voice;
    logic                    pulse_reset;
  } out_t;

endpackage
`default_nettype wire

// ===== design/lsvm_sample_mem.sv =====
`default_nettype none
module lsvm_sample_mem
  import lsvm_pkg::*;
#(
  parameter int NUM_VOICES  = DEF_NUM_VOICES,
  parameter int VOICE_DEPTH = DEF_VOICE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int ADDR_W     = $clog2(VOICE_DEPTH),
  localparam int MEM_AW     = VIDX_W + ADDR_W
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [MEM_AW-1:0]             waddr,
  input  wire logic signed [SAMPLE_BITS-1:0] wdata,
  input  wire logic [MEM_AW-1:0]             raddr,
  output logic signed [SAMPLE_BITS-1:0]      rdata
);

  localparam int MEM_DEPTH = NUM_VOICES * (2 ** ADDR_W);

  logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/lsvm_voice_table.sv =====
`default_nettype none
module lsvm_voice_table
  import lsvm_pkg::*;
#(
  parameter int NUM_VOICES  = DEF_NUM_VOICES,
  parameter int VOICE_DEPTH = DEF_VOICE_DEPTH,
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int LEN_W      = $clog2(VOICE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // control write
  input  wire logic               ctrl_we,
  input  wire logic [VIDX_W-1:0]  ctrl_idx,
  input  wire logic [LEN_W-1:0]   ctrl_len,
  input  wire logic [GAIN_W-1:0]  ctrl_gain,
  input  wire logic [FLAGS_W-1:0] ctrl_flags,
  // position write
  input  wire logic               pos_we,
  input  wire logic [VIDX_W-1:0]  pos_idx,
  input  wire logic [LEN_W-1:0]   pos_wdata,
  // registered read
  input  wire logic [VIDX_W-1:0]  rd_idx,
  output logic [LEN_W-1:0]        rd_len,
  output logic [GAIN_W-1:0]       rd_gain,
  output logic [FLAGS_W-1:0]      rd_flags,
  output logic [LEN_W-1:0]        rd_pos
);

  localparam int CTRL_W = LEN_W + GAIN_W + FLAGS_W;

  logic [CTRL_W-1:0]     ctrl_mem [NUM_VOICES];
  logic [LEN_W-1:0]      pos_mem  [NUM_VOICES];
  logic [NUM_VOICES-1:0] ctrl_vld;
  logic [NUM_VOICES-1:0] pos_vld;

  logic [CTRL_W-1:0] ctrl_q;
  logic [LEN_W-1:0]  pos_q;
  logic              ctrl_vld_q;
  logic              pos_vld_q;

  // valid bits stand in for the zero reset of both tables
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_vld <= '0;
      pos_vld  <= '0;
    end else begin
      if (ctrl_we) begin
        ctrl_vld[ctrl_idx] <= 1'b1;
      end
      if (pos_we) begin
        pos_vld[pos_idx] <= 1'b1;
      end
    end
  end

  // table storage and registered read
  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      ctrl_mem[ctrl_idx] <= {ctrl_len, ctrl_gain, ctrl_flags};
    end
    if (pos_we) begin
      pos_mem[pos_idx] <= pos_wdata;
    end
    ctrl_q     <= ctrl_mem[rd_idx];
    pos_q      <= pos_mem[rd_idx];
    ctrl_vld_q <= ctrl_vld[rd_idx];
    pos_vld_q  <= pos_vld[rd_idx];
  end

  // unwritten entries read as zero
  always_comb begin
    if (ctrl_vld_q) begin
      {rd_len, rd_gain, rd_flags} = ctrl_q;
    end else begin
      {rd_len, rd_gain, rd_flags} = '0;
    end
    rd_pos = pos_vld_q ? pos_q : '0;
  end

endmodule
`default_nettype wire

// ===== design/lsvm_mac.sv =====
`default_nettype none
module lsvm_mac
  import lsvm_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic                          in_vld,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [GAIN_W-1:0]             gain,
  output logic signed [MIX_W-1:0]            sum,
  output logic                               busy
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int TERM_W = PROD_W - Q_SHIFT;
  localparam int ACC_W  = ((TERM_W > MIX_W) ? TERM_W : MIX_W) + 1;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc;

  // multiply stage, gain taken as unsigned
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= in_vld;
    end
    prod <= $signed(sample) * $signed({1'b0, gain});
  end

  // floor shift, add, saturate
  always_comb begin
    term = $signed(prod[PROD_W-1:Q_SHIFT]);
    acc  = ACC_W'(sum) + ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
    end else if (prod_vld) begin
      priority if (acc > MIX_MAX) begin
        sum <= MIX_SAT_MAX;
      end else if (acc < MIX_MIN) begin
        sum <= MIX_SAT_MIN;
      end else begin
        sum <= acc[MIX_W-1:0];
      end
    end
  end

  assign busy = prod_vld;

endmodule
`default_nettype wire

// ===== design/looping_sample_voice_mixer_top.sv =====
// Looping sample voice mixer.
// Input channel (in_valid/in_ready/in_data) carries one command per beat:
// a sample write, a voice control write or a mix tick. Output channel
// (out_valid/out_ready/out_data) carries one beat per mix tick only.
// Config port (cfg_we/cfg_index/cfg_data) sets sync enable and the pulse
// voice; writes take effect at once and must be made while the block is
// idle, which the block itself does not enforce. Sample and control writes
// keep the block idle, so a new command can follow each one. A tick steps a
// sequencer through all NUM_VOICES voices, one voice per cycle through a
// shared gain multiplier and saturating adder, then waits in the drain state
// until the pipeline is empty; its result is loaded into the output register
// from the finish state, and the next command is taken once back in idle.
// Registered voice table and sample memory reads set the pipeline depth.
// Reset clears all voice controls and positions at once through valid bits,
// with no clearing pass; sample memory holds no defined value until written.
// The result sits in an output register: a stalled receiver does not block
// new commands, but the next tick waits to load its result until the
// previous one has been taken.
`default_nettype none
`include "assert_macros.svh"
module looping_sample_voice_mixer_top
  import lsvm_pkg::*;
#(
  parameter int NUM_VOICES  = DEF_NUM_VOICES,
  parameter int VOICE_DEPTH = DEF_VOICE_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int ADDR_W = $clog2(VOICE_DEPTH);
  localparam int LEN_W  = $clog2(VOICE_DEPTH + 1);
  localparam int MEM_AW = VIDX_W + ADDR_W;
  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic                 sync_enable;
  logic [7:0]           pulse_voice;
  logic                 pulse_wrapped;
  logic                 tick_last;
  logic                 any_act;
  logic [VIDX_W-1:0]    issue_idx;

  logic                 s1_vld;
  logic [VIDX_W-1:0]    s1_idx;
  logic                 s2_vld;
  logic                 s2_act;
  logic [GAIN_W-1:0]    s2_gain;

  logic                 in_acc;
  logic                 voice_ok;
  logic                 addr_ok;
  logic                 wr_sample;
  logic                 wr_ctrl;
  logic                 tick_start;
  logic [LEN_W-1:0]     len_sat;

  logic [LEN_W-1:0]     vt_len;
  logic [GAIN_W-1:0]    vt_gain;
  logic [FLAGS_W-1:0]   vt_flags;
  logic [LEN_W-1:0]     vt_pos;

  logic                 s1_act;
  logic                 s1_wrap;
  logic [LEN_W-1:0]     pos_eff;
  logic                 pos_we;
  logic [VIDX_W-1:0]    pos_idx;
  logic [LEN_W-1:0]     pos_wdata;

  logic signed [SAMPLE_BITS-1:0] smp_rd;
  logic signed [MIX_W-1:0]       mix_sum;
  logic                          mac_busy;
  logic                          out_load;
  out_t                          out_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_enable <= 1'b0;
      pulse_voice <= PULSE_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_ENABLE: sync_enable <= cfg_data[0];
        REG_PULSE_VOICE: pulse_voice <= cfg_data;
        default: ;
      endcase
    end
  end

  // command decode at the input beat
  always_comb begin
    in_ready   = (state == ST_IDLE);
    in_acc     = in_valid && in_ready;
    voice_ok   = 32'(in_data.voice_index) < NUM_VOICES;
    addr_ok    = 32'(in_data.sample_address) < VOICE_DEPTH;
    wr_sample  = in_acc && (in_data.func == FUNC_WR_SAMPLE) && voice_ok && addr_ok;
    wr_ctrl    = in_acc && (in_data.func == FUNC_WR_CTRL) && voice_ok;
    tick_start = in_acc && (in_data.func == FUNC_TICK);
    if (32'(in_data.loop_length) > VOICE_DEPTH) begin
      len_sat = LEN_W'(VOICE_DEPTH);
    end else begin
      len_sat = LEN_W'(in_data.loop_length);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (tick_start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue_idx == LAST_VOICE) begin
            issue_idx <= '0;
            state     <= ST_DRAIN;
          end else begin
            issue_idx <= issue_idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_vld && !s2_vld && !mac_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // voice stage: wrap, sample address, position update
  always_comb begin
    s1_act    = s1_vld && (vt_flags == FLAG_ACTIVE) && (vt_len != '0);
    s1_wrap   = vt_pos >= vt_len;
    pos_eff   = s1_wrap ? '0 : vt_pos;
    pos_we    = s1_act || (wr_ctrl && in_data.restart_position);
    pos_idx   = s1_act ? s1_idx : VIDX_W'(in_data.voice_index);
    pos_wdata = s1_act ? (pos_eff + 1'b1) : '0;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= (state == ST_RUN);
      s2_vld <= s1_vld;
    end
    s1_idx  <= issue_idx;
    s2_act  <= s1_act;
    s2_gain <= vt_gain;
  end

  // tick flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_wrapped <= 1'b0;
      any_act       <= 1'b0;
      tick_last     <= 1'b0;
    end else begin
      if (tick_start) begin
        any_act   <= 1'b0;
        tick_last <= in_data.last_in_block;
      end else if (s1_act) begin
        any_act <= 1'b1;
      end
      if (s1_act && s1_wrap && sync_enable && (32'(s1_idx) == 32'(pulse_voice))) begin
        pulse_wrapped <= 1'b1;
      end else if (out_load && tick_last) begin
        pulse_wrapped <= 1'b0;
      end
    end
  end

  lsvm_voice_table #(
    .NUM_VOICES  (NUM_VOICES),
    .VOICE_DEPTH (VOICE_DEPTH)
  ) u_voice_table (
    .clk        (clk),
    .rst        (rst),
    .ctrl_we    (wr_ctrl),
    .ctrl_idx   (VIDX_W'(in_data.voice_index)),
    .ctrl_len   (len_sat),
    .ctrl_gain  (in_data.loop_gain),
    .ctrl_flags ({in_data.loop_usable, in_data.loop_playing}),
    .pos_we     (pos_we),
    .pos_idx    (pos_idx),
    .pos_wdata  (pos_wdata),
    .rd_idx     (issue_idx),
    .rd_len     (vt_len),
    .rd_gain    (vt_gain),
    .rd_flags   (vt_flags),
    .rd_pos     (vt_pos)
  );

  lsvm_sample_mem #(
    .NUM_VOICES  (NUM_VOICES),
    .VOICE_DEPTH (VOICE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sample_mem (
    .clk   (clk),
    .we    (wr_sample),
    .waddr ({VIDX_W'(in_data.voice_index), ADDR_W'(in_data.sample_address)}),
    .wdata (SAMPLE_BITS'(in_data.sample_value)),
    .raddr (MEM_AW'({s1_idx, pos_eff[ADDR_W-1:0]})),
    .rdata (smp_rd)
  );

  lsvm_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (tick_start),
    .in_vld (s2_vld && s2_act),
    .sample (smp_rd),
    .gain   (s2_gain),
    .sum    (mix_sum),
    .busy   (mac_busy)
  );

  // output register
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_q.mix_sample  <= mix_sum;
      out_q.any_voice   <= any_act;
      out_q.pulse_reset <= tick_last && pulse_wrapped && sync_enable;
    end
  end

  assign out_data = out_q;

  // checks
  `ASSERT_IMPL(a_idle_idx_zero, state != ST_RUN, issue_idx == '0)
  `ASSERT_IMPL(a_finish_drained, state == ST_FINISH, !s1_vld && !s2_vld && !mac_busy)
  `ASSERT_IMPL(a_out_from_finish, $rose(out_valid), $past(state) == ST_FINISH)

endmodule
`default_nettype wire
